// ===== hw/rtl/jacobi_poisson_stencil_sweep_defines.svh =====
// Assertion macros used by the stencil sweep RTL.
`ifndef JACOBI_POISSON_STENCIL_SWEEP_DEFINES_SVH
`define JACOBI_POISSON_STENCIL_SWEEP_DEFINES_SVH
`ifndef SYNTHESIS
`define JPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define JPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define JPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define JPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/jps_pkg.sv =====
package jps_pkg;
  // Register indexes of the configuration port.
  localparam logic [1:0] REG_GRID_SIZE       = 2'd0;
  localparam logic [1:0] REG_SPACING_SQUARED = 2'd1;
  localparam logic [1:0] REG_TOLERANCE       = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0]  GRID_SIZE_RST = 8'd32;
  localparam logic [31:0] SPACING_RST   = 32'd3943955;
  localparam logic [31:0] TOLERANCE_RST = 32'd66;

  localparam int MAX_INTERIOR_DEF = 254;

  // Iterative divider: 49-bit dividend, 32-bit divisor.
  localparam int DIV_W = 49;
  localparam int SUM_W = 48;
  localparam int CNT_W = 17;
endpackage

// ===== hw/rtl/jacobi_poisson_stencil_sweep.sv =====
// One Jacobi sweep of the 2-D Poisson equation with a five-point stencil.
// The input channel (in_*) carries old u and source f over the bordered
// (N+2)x(N+2) grid in raster order, one grid point per transaction.
// The result channel (out_*) carries one transaction per interior point,
// in raster order; tlast marks the last interior point, which also holds
// the mean relative change and the converged flag.
// Configuration is written through cfg_* while the block is idle; writing
// the grid size restarts the sweep.
// Each point is handled alone: line store read, write back and multiply,
// stencil sum, then a 49-step bit-serial divider for the relative change
// of nonzero results, accumulation, one more 49-step pass for the mean on
// the last point of a sweep with nonzero results, and the load of the
// output register. Border points end after write back with no result;
// interior points skip the divider when the new value is zero.
// Reset clears position, accumulators and the output valid flag; the line
// stores need no clearing since each sweep fills rows before reading them.
// A stalled receiver holds the result in the output register; the block
// takes the next point meanwhile and waits only when the next result is due.
`include "jacobi_poisson_stencil_sweep_defines.svh"
module jacobi_poisson_stencil_sweep #(
  parameter int MAX_INTERIOR = jps_pkg::MAX_INTERIOR_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] old_value, [63:32] source_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] new_value, [63:32] mean_change
  output logic        out_tlast,  // sweep_done
  output logic        out_tuser   // converged
);
  import jps_pkg::*;

  localparam int DEPTH = MAX_INTERIOR + 2;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [31:0] MAX32 = 32'(MAX_INTERIOR);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_MUL, S_DIV, S_ACC, S_MEAN, S_FIN
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [7:0]  grid_r;
  logic [31:0] h2_r;
  logic [31:0] tol_r;

  // Grid position and accumulators.
  logic [AW-1:0]    col_r, row_r;
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] cnt_r;

  // Line stores and their registered read data.
  logic [31:0] up_mem  [DEPTH];
  logic [31:0] mid_mem [DEPTH];
  logic [31:0] src_mem [DEPTH];
  logic [31:0] up_q, mid_c_q, mid_n_q, src_q;

  // Per-point operands.
  logic [31:0] old_r, srcin_r, left_hold_r;
  logic [31:0] up_op_r, left_op_r, right_op_r, centre_r;
  logic        fneg_r, done_r, nz_r;
  logic [63:0] prod_r;
  logic [31:0] nv_r;

  // Divider.
  logic [DIV_W-1:0] dq_r;
  logic [31:0]      drem_r, dd_r;
  logic [5:0]       dcnt_r;

  // Output register.
  logic        out_valid_r, out_last_r, out_user_r;
  logic [31:0] out_nv_r, out_mean_r;

  // Clamped interior size.
  logic [31:0]   n_ext;
  logic [AW-1:0] n_s;
  always_comb begin
    priority if (grid_r == 8'd0) begin
      n_ext = 32'd1;
    end else if ({24'd0, grid_r} > MAX32) begin
      n_ext = MAX32;
    end else begin
      n_ext = {24'd0, grid_r};
    end
    n_s = n_ext[AW-1:0];
  end

  logic [AW-1:0] col_p1;
  assign col_p1 = AW'({1'b0, col_r} + (AW+1)'(1));

  logic interior, last_pt;
  assign interior = (row_r >= AW'(2)) && (col_r >= AW'(1)) && (col_r <= n_s);
  assign last_pt  = (row_r == AW'(n_ext + 32'd1)) && (col_r == n_s);

  logic accept;
  assign in_tready = (state_r == S_IDLE) && !cfg_wr_en;
  assign accept    = in_tvalid && in_tready;

  // Line store reads every cycle at the current column; writes on write back.
  always_ff @(posedge clk) begin
    up_q    <= up_mem[col_r];
    mid_c_q <= mid_mem[col_r];
    mid_n_q <= mid_mem[col_p1];
    src_q   <= src_mem[col_r];
    if (state_r == S_READ) begin
      up_mem[col_r]  <= mid_c_q;
      mid_mem[col_r] <= old_r;
      src_mem[col_r] <= srcin_r;
    end
  end

  // Source magnitude times h^2.
  logic [31:0] fmag;
  assign fmag = src_q[31] ? (32'd0 - src_q) : src_q;

  // Stencil sum, floor divide by four, saturation.
  logic signed [35:0] term_s, total_s, nv_s;
  logic [32:0]        ceil_hi;
  logic [31:0]        nv_sat;
  always_comb begin
    ceil_hi = 33'((({1'b0, prod_r} + 65'h0_FFFF_FFFF) >> 32));
    if (fneg_r) begin
      term_s = -$signed({3'd0, ceil_hi});
    end else begin
      term_s = $signed({4'd0, prod_r[63:32]});
    end
    total_s = 36'($signed(up_op_r)) + 36'($signed(old_r)) + 36'($signed(left_op_r))
            + 36'($signed(right_op_r)) + term_s;
    nv_s = total_s >>> 2;
    priority if (nv_s > 36'sh0_7FFF_FFFF) begin
      nv_sat = 32'h7FFF_FFFF;
    end else if (nv_s < -36'sh0_8000_0000) begin
      nv_sat = 32'h8000_0000;
    end else begin
      nv_sat = nv_s[31:0];
    end
  end

  // Relative change operands.
  logic signed [32:0] diff_s;
  logic [32:0]        diff_mag;
  logic [31:0]        nv_mag;
  assign diff_s   = 33'($signed(nv_sat)) - 33'($signed(centre_r));
  assign diff_mag = diff_s[32] ? (33'd0 - diff_s) : diff_s;
  assign nv_mag   = nv_sat[31] ? (32'd0 - nv_sat) : nv_sat;

  // One restoring divider step.
  logic [32:0] rem_sh;
  logic        ge;
  assign rem_sh = {drem_r, dq_r[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dd_r};

  logic [31:0] q_sat;
  assign q_sat = (|dq_r[DIV_W-1:32]) ? 32'hFFFF_FFFF : dq_r[31:0];

  // Accumulation with saturation.
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  always_comb begin
    sum_add = {1'b0, sum_r} + {17'd0, q_sat};
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (nz_r) begin
      sum_nxt = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
      cnt_nxt = (&cnt_r) ? cnt_r : cnt_r + CNT_W'(1);
    end
  end

  logic fin_go;
  assign fin_go = (state_r == S_FIN) && (!out_valid_r || out_tready);

  // Control, datapath registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      grid_r      <= GRID_SIZE_RST;
      h2_r        <= SPACING_RST;
      tol_r       <= TOLERANCE_RST;
      col_r       <= '0;
      row_r       <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !fin_go) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_GRID_SIZE: begin
            grid_r <= cfg_wdata[7:0];
            col_r  <= '0;
            row_r  <= '0;
            sum_r  <= '0;
            cnt_r  <= '0;
          end
          REG_SPACING_SQUARED: h2_r  <= cfg_wdata;
          REG_TOLERANCE:       tol_r <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            old_r   <= in_tdata[31:0];
            srcin_r <= in_tdata[63:32];
            state_r <= S_READ;
          end
        end
        S_READ: begin
          up_op_r     <= up_q;
          left_op_r   <= left_hold_r;
          right_op_r  <= mid_n_q;
          centre_r    <= mid_c_q;
          left_hold_r <= mid_c_q;
          fneg_r      <= src_q[31];
          prod_r      <= fmag * h2_r;
          done_r      <= last_pt;
          if (col_r > n_s) begin
            col_r <= '0;
            row_r <= (row_r > n_s) ? '0 : row_r + AW'(1);
          end else begin
            col_r <= col_r + AW'(1);
          end
          state_r <= interior ? S_MUL : S_IDLE;
        end
        S_MUL: begin
          nv_r   <= nv_sat;
          nz_r   <= (nv_sat != 32'd0);
          dq_r   <= {diff_mag, 16'd0};
          dd_r   <= nv_mag;
          drem_r <= '0;
          dcnt_r <= '0;
          state_r <= (nv_sat != 32'd0) ? S_DIV : S_ACC;
        end
        S_DIV, S_MEAN: begin
          drem_r <= ge ? 32'(rem_sh - {1'b0, dd_r}) : rem_sh[31:0];
          dq_r   <= {dq_r[DIV_W-2:0], ge};
          dcnt_r <= dcnt_r + 6'd1;
          if (dcnt_r == 6'(DIV_W - 1)) begin
            state_r <= (state_r == S_DIV) ? S_ACC : S_FIN;
          end
        end
        S_ACC: begin
          sum_r  <= sum_nxt;
          cnt_r  <= cnt_nxt;
          dq_r   <= {1'b0, sum_nxt};
          dd_r   <= {15'd0, cnt_nxt};
          drem_r <= '0;
          dcnt_r <= '0;
          state_r <= (done_r && cnt_nxt != '0) ? S_MEAN : S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            out_valid_r <= 1'b1;
            out_nv_r    <= nv_r;
            out_last_r  <= done_r;
            if (done_r) begin
              out_mean_r <= (cnt_r != '0) ? q_sat : 32'd0;
              out_user_r <= ((cnt_r != '0) ? q_sat : 32'd0) <= tol_r;
              sum_r      <= '0;
              cnt_r      <= '0;
            end else begin
              out_mean_r <= '0;
              out_user_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_mean_r, out_nv_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  // The divider never runs past its last step.
  `JPS_ASSERT_IMP(a_div_bound, clk, rst_n, (state_r == S_DIV || state_r == S_MEAN), (dcnt_r < 6'(DIV_W)))
  // Accumulators clear once the last result of a sweep is loaded.
  `JPS_ASSERT_NXT(a_sweep_clear, clk, rst_n, (fin_go && done_r), (sum_r == '0 && cnt_r == '0))
  // Summary fields are zero except on the last point.
  `JPS_ASSERT_IMP(a_summary_zero, clk, rst_n, (out_valid_r && !out_last_r), (out_mean_r == 32'd0 && !out_user_r))
endmodule

// ===== tb/sv/tb_jacobi_poisson_stencil_sweep.sv =====
module tb_jacobi_poisson_stencil_sweep;
  import jps_pkg::*;

  localparam int ITEM_TARGET = 1850;
  localparam int SETTLE_CYCLES = 300;

  // One expected interior result.
  typedef struct {
    logic [31:0] new_value;
    logic        sweep_done;
    logic [31:0] mean_change;
    logic        converged;
  } stencil_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [31:0] old_value, [63:32] source_value
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [31:0] new_value, [63:32] mean_change
  logic        out_tlast;  // sweep_done
  logic        out_tuser;  // converged

  jacobi_poisson_stencil_sweep dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  // Predictor state: configuration, grid position, line stores, accumulators.
  logic [7:0]  grid_reg;
  logic [31:0] spacing_reg;
  logic [31:0] tolerance_reg;
  int unsigned row_pos;
  int unsigned col_pos;
  logic [31:0] upper_line [256];
  logic [31:0] middle_line [256];
  logic [31:0] source_line [256];
  logic [31:0] left_neighbor;
  longint unsigned change_acc;
  int unsigned nonzero_pts;

  stencil_result_t pending_results[$];
  int error_count;
  int points_sent;
  int results_seen;
  int sweeps_done_seen;
  int converged_seen;
  bit calm;
  int hold_request;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic int unsigned interior_points();
    if (grid_reg == 8'd0) return 1;
    if (grid_reg > 8'd254) return 254;
    return grid_reg;
  endfunction

  // Advance the stencil predictor by one grid point.
  function automatic void predict_point(logic [31:0] old_bits, logic [31:0] src_bits);
    int unsigned n;
    longint up, centre, right, left, down, f, term, total, nv;
    longint unsigned prod, q, mean;
    stencil_result_t res;
    n = interior_points();
    if (row_pos >= 2 && col_pos >= 1 && col_pos <= n) begin
      up     = longint'(signed'(upper_line[col_pos]));
      centre = longint'(signed'(middle_line[col_pos]));
      right  = longint'(signed'(middle_line[col_pos + 1]));
      left   = longint'(signed'(left_neighbor));
      down   = longint'(signed'(old_bits));
      f      = longint'(signed'(source_line[col_pos]));
      prod   = magnitude(f) * longint'({32'd0, spacing_reg});
      if (f < 0) term = -longint'((prod + 64'hFFFF_FFFF) >> 32);
      else term = longint'(prod >> 32);
      total = up + down + left + right + term;
      if (total >= 0) nv = total >>> 2;
      else nv = -longint'((magnitude(total) + 3) >> 2);
      if (nv > 64'sd2147483647) nv = 64'sd2147483647;
      if (nv < -64'sd2147483648) nv = -64'sd2147483648;
      if (nv != 0) begin
        q = (magnitude(nv - centre) << 16) / magnitude(nv);
        if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
        change_acc += q;
        if (change_acc > 64'hFFFF_FFFF_FFFF) change_acc = 64'hFFFF_FFFF_FFFF;
        if (nonzero_pts < 17'h1FFFF) nonzero_pts++;
      end
      res.new_value = nv[31:0];
      res.sweep_done = (row_pos == n + 1 && col_pos == n);
      res.mean_change = '0;
      res.converged = 1'b0;
      if (res.sweep_done) begin
        mean = (nonzero_pts != 0) ? change_acc / nonzero_pts : 0;
        if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
        res.mean_change = mean[31:0];
        res.converged = (mean <= tolerance_reg);
        change_acc = 0;
        nonzero_pts = 0;
      end
      pending_results.push_back(res);
    end
    left_neighbor = middle_line[col_pos];
    upper_line[col_pos] = middle_line[col_pos];
    middle_line[col_pos] = old_bits;
    source_line[col_pos] = src_bits;
    col_pos++;
    if (col_pos > n + 1) begin
      col_pos = 0;
      row_pos++;
      if (row_pos > n + 1) row_pos = 0;
    end
  endfunction

  // Send one grid point; called and returning at a falling edge.
  task automatic send_point(logic [31:0] old_bits, logic [31:0] src_bits);
    if (!calm && $urandom_range(99) < 20) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {src_bits, old_bits};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_point(old_bits, src_bits);
    points_sent++;
    @(negedge clk);
  endtask

  // Wait until all results are in and the block has gone quiet.
  task automatic drain_idle();
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_GRID_SIZE: begin
        grid_reg = value[7:0];
        row_pos = 0;
        col_pos = 0;
        change_acc = 0;
        nonzero_pts = 0;
      end
      REG_SPACING_SQUARED: spacing_reg = value;
      REG_TOLERANCE: tolerance_reg = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Pick a grid value: full random, smooth around a base, or mostly an extreme.
  function automatic logic [31:0] pick_value(int style, logic [31:0] base);
    case (style)
      0: return $urandom;
      1: return base + $urandom_range(64) - 32;
      default: begin
        case ($urandom_range(5))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'd0;
          3: return 32'd1;
          4: return 32'hFFFF_FFFF;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Stream count grid points of one style.
  task automatic stream_grid(int style, int count);
    logic [31:0] base;
    logic [31:0] src_base;
    base = $urandom_range(1, 3) << $urandom_range(8, 24);
    src_base = (style == 1) ? 32'd0 : $urandom;
    for (int k = 0; k < count; k++) begin
      send_point(pick_value(style, base),
                 (style == 1) ? src_base : pick_value(style, src_base));
    end
  endtask

  task automatic test_directed();
    int g;
    write_reg(REG_GRID_SIZE, 8'd0);
    write_reg(REG_SPACING_SQUARED, 32'hFFFF_FFFF);
    write_reg(REG_TOLERANCE, 32'hFFFF_FFFF);
    // All neighbors and source at the positive limit: new value saturates.
    for (g = 0; g < 9; g++) send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // Negative limit with a negative source term.
    for (g = 0; g < 9; g++) send_point(32'h8000_0000, 32'h8000_0000);
    drain_idle();
    write_reg(REG_SPACING_SQUARED, 32'd0);
    write_reg(REG_TOLERANCE, 32'd0);
    // A zero grid with zero spacing has no nonzero points, so the sweep counts as converged.
    for (g = 0; g < 9; g++) send_point(32'd0, 32'hFFFF_FFFF);
    drain_idle();
  endtask

  task automatic test_grid_sizes();
    write_reg(REG_SPACING_SQUARED, SPACING_RST);
    write_reg(REG_TOLERANCE, TOLERANCE_RST);
    for (int n = 1; n <= 6; n++) begin
      write_reg(REG_GRID_SIZE, n[7:0]);
      stream_grid(n % 3, (n + 2) * (n + 2));
      stream_grid(1, (n + 2) * (n + 2));
      drain_idle();
    end
  endtask

  task automatic test_largest_grid();
    // 255 clamps to the largest interior size, 254; two rows prime the line stores.
    write_reg(REG_GRID_SIZE, 8'd255);
    stream_grid(0, 2 * 256 + 20);
    drain_idle();
  endtask

  task automatic test_backpressure();
    write_reg(REG_GRID_SIZE, 8'd4);
    calm = 1'b1;
    hold_request = 3000;
    stream_grid(1, 36);
    stream_grid(0, 36);
    calm = 1'b0;
    drain_idle();
  endtask

  task automatic test_random_sweeps();
    int n;
    while (points_sent < ITEM_TARGET) begin
      n = $urandom_range(1, 7);
      write_reg(REG_GRID_SIZE, n[7:0]);
      case ($urandom_range(3))
        0: write_reg(REG_SPACING_SQUARED, $urandom);
        1: write_reg(REG_TOLERANCE, $urandom_range(2000));
        2: write_reg(REG_TOLERANCE, $urandom);
        default: ;
      endcase
      calm = ($urandom_range(9) == 0);
      stream_grid($urandom_range(2), (n + 2) * (n + 2));
      // Occasionally a second sweep at the same size without a restart.
      if ($urandom_range(3) == 0) stream_grid(1, (n + 2) * (n + 2));
      calm = 1'b0;
      drain_idle();
    end
  endtask

  // Result receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    static int hold_left = 0;
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 20);
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    stencil_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: new_value %h done %b mean %h conv %b", $time,
                 out_tdata[31:0], out_tlast, out_tdata[63:32], out_tuser);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_tlast) sweeps_done_seen++;
        if (out_tlast && out_tuser) converged_seen++;
        if (out_tdata[31:0] !== exp_res.new_value) begin
          $display("%0t: new_value expected %h actual %h", $time,
                   exp_res.new_value, out_tdata[31:0]);
          error_count++;
        end
        if (out_tlast !== exp_res.sweep_done) begin
          $display("%0t: sweep_done expected %b actual %b", $time,
                   exp_res.sweep_done, out_tlast);
          error_count++;
        end
        if (out_tdata[63:32] !== exp_res.mean_change) begin
          $display("%0t: mean_change expected %h actual %h", $time,
                   exp_res.mean_change, out_tdata[63:32]);
          error_count++;
        end
        if (out_tuser !== exp_res.converged) begin
          $display("%0t: converged expected %b actual %b", $time,
                   exp_res.converged, out_tuser);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    calm = 1'b0;
    hold_request = 0;
    error_count = 0;
    points_sent = 0;
    results_seen = 0;
    sweeps_done_seen = 0;
    converged_seen = 0;
    grid_reg = GRID_SIZE_RST;
    spacing_reg = SPACING_RST;
    tolerance_reg = TOLERANCE_RST;
    row_pos = 0;
    col_pos = 0;
    change_acc = 0;
    nonzero_pts = 0;
    left_neighbor = '0;
    for (int k = 0; k < 256; k++) begin
      upper_line[k] = '0;
      middle_line[k] = '0;
      source_line[k] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_grid_sizes();
    test_largest_grid();
    test_backpressure();
    test_random_sweeps();

    $display("Sent %0d grid points; checked %0d interior results over %0d sweeps.",
             points_sent, results_seen, sweeps_done_seen);
    $display("Sweeps flagged converged: %0d; grid sizes 1 to 7 plus the largest.",
             converged_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #50_000_000;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
